// ===== rtl/fspa_pkg.sv =====
// Shared types and codes for the fixed slot pool allocator.
package fspa_pkg;

    // Command codes carried in the operation field
    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_RESET = 2'd2,
        OP_NONE  = 2'd3
    } op_e;

    // Completion codes carried in the status field
    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_EMPTY  = 2'd1,
        STATUS_RANGE  = 2'd2,
        STATUS_DOUBLE = 2'd3
    } status_e;

    // Sequencer states
    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2
    } state_e;

    localparam int unsigned SLOT_IN_W  = 11;
    localparam int unsigned SLOT_OUT_W = 10;

    typedef struct packed {
        logic [1:0]            operation;
        logic [SLOT_IN_W-1:0]  slot_to_free;
    } cmd_t;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot_given;
        logic [1:0]            status;
    } result_t;

    // Result transaction handed from the sequencer to the output register
    typedef struct packed {
        logic    strobe;
        result_t item;
    } res_xfer_t;

endpackage

// ===== rtl/fspa_slot_ram.sv =====
// Single-port-write, single-port-read slot memory with registered read data.
module fspa_slot_ram #(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned WIDTH  = 12,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/fspa_ctrl.sv =====
// Sequencer: free-list head, slot checks, memory read-modify-write and relink sweep.
module fspa_ctrl #(
    parameter int unsigned POOL_SLOTS = 1024,
    parameter int unsigned SLOT_W     = $clog2(POOL_SLOTS),
    parameter int unsigned LINK_W     = $clog2(POOL_SLOTS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  fspa_pkg::cmd_t        cmd,
    output logic                  busy,
    output fspa_pkg::res_xfer_t   res_next,
    output logic                  rd_en,
    output logic [SLOT_W-1:0]     rd_addr,
    input  logic [LINK_W:0]       rd_data,
    output logic                  wr_en,
    output logic [SLOT_W-1:0]     wr_addr,
    output logic [LINK_W:0]       wr_data
);

    localparam int unsigned IDX_WIDE_W = SLOT_W + fspa_pkg::SLOT_IN_W;
    localparam logic [IDX_WIDE_W-1:0] POOL_IDX   = IDX_WIDE_W'(POOL_SLOTS);
    localparam logic [LINK_W-1:0]     POOL_LINK  = LINK_W'(POOL_SLOTS);
    localparam logic [SLOT_W-1:0]     LAST_SLOT  = SLOT_W'(POOL_SLOTS - 1);

    fspa_pkg::state_e                 state_reg, state_next;
    logic [LINK_W-1:0]                head_reg, head_next;
    logic [SLOT_W-1:0]                clr_cnt_reg, clr_cnt_next;
    fspa_pkg::op_e                    op_reg, op_next;
    logic [fspa_pkg::SLOT_IN_W-1:0]   idx_reg, idx_next;

    logic                             accept;
    logic [IDX_WIDE_W-1:0]            cmd_idx_wide;
    logic [IDX_WIDE_W-1:0]            reg_idx_wide;
    logic [SLOT_W:0]                  cnt_plus;
    logic [SLOT_W+LINK_W:0]           cnt_plus_wide;
    logic [LINK_W+fspa_pkg::SLOT_IN_W-1:0] idx_link_wide;
    logic [LINK_W+fspa_pkg::SLOT_OUT_W-1:0] head_given_wide;
    logic                             rd_busy_mark;
    logic [LINK_W-1:0]                rd_link;

    assign accept        = start && (state_reg == fspa_pkg::S_IDLE);
    assign busy          = (state_reg != fspa_pkg::S_IDLE);
    assign cmd_idx_wide  = {{SLOT_W{1'b0}}, cmd.slot_to_free};
    assign reg_idx_wide  = {{SLOT_W{1'b0}}, idx_reg};
    assign cnt_plus      = {1'b0, clr_cnt_reg} + 1'b1;
    assign cnt_plus_wide = {{LINK_W{1'b0}}, cnt_plus};
    assign idx_link_wide = {{LINK_W{1'b0}}, idx_reg};
    assign head_given_wide = {{fspa_pkg::SLOT_OUT_W{1'b0}}, head_reg};
    assign rd_busy_mark  = rd_data[LINK_W];
    assign rd_link       = rd_data[LINK_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fspa_pkg::S_CLEAR;
            head_reg    <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        idx_reg <= idx_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        clr_cnt_next  = clr_cnt_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        res_next      = '0;
        rd_en         = 1'b0;
        rd_addr       = head_reg[SLOT_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = clr_cnt_reg;
        wr_data       = {1'b0, cnt_plus_wide[LINK_W-1:0]};

        case (state_reg)
            fspa_pkg::S_CLEAR:
            begin
                // relink entry i to i+1 and mark it free
                wr_en        = 1'b1;
                clr_cnt_next = cnt_plus[SLOT_W-1:0];
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    clr_cnt_next = '0;
                    state_next   = fspa_pkg::S_IDLE;
                end
            end

            fspa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = fspa_pkg::op_e'(cmd.operation);
                    idx_next = cmd.slot_to_free;
                    case (fspa_pkg::op_e'(cmd.operation))
                        fspa_pkg::OP_ALLOC:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg[SLOT_W-1:0];
                            state_next = fspa_pkg::S_EXEC;
                        end
                        fspa_pkg::OP_FREE:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = cmd_idx_wide[SLOT_W-1:0];
                            state_next = fspa_pkg::S_EXEC;
                        end
                        fspa_pkg::OP_RESET:
                        begin
                            res_next.strobe      = 1'b1;
                            res_next.item.status = fspa_pkg::STATUS_OK;
                            head_next            = '0;
                            clr_cnt_next         = '0;
                            state_next           = fspa_pkg::S_CLEAR;
                        end
                        default:
                        begin
                            res_next.strobe      = 1'b1;
                            res_next.item.status = fspa_pkg::STATUS_OK;
                        end
                    endcase
                end
            end

            fspa_pkg::S_EXEC:
            begin
                res_next.strobe = 1'b1;
                state_next      = fspa_pkg::S_IDLE;
                if (op_reg == fspa_pkg::OP_ALLOC)
                begin
                    if (head_reg >= POOL_LINK)
                    begin
                        res_next.item.status = fspa_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        // pop head: mark in use, keep its link
                        wr_en     = 1'b1;
                        wr_addr   = head_reg[SLOT_W-1:0];
                        wr_data   = {1'b1, rd_link};
                        head_next = rd_link;
                        res_next.item.slot_given =
                            head_given_wide[fspa_pkg::SLOT_OUT_W-1:0];
                        res_next.item.status = fspa_pkg::STATUS_OK;
                    end
                end
                else
                begin
                    if (reg_idx_wide >= POOL_IDX)
                    begin
                        res_next.item.status = fspa_pkg::STATUS_RANGE;
                    end
                    else if (!rd_busy_mark)
                    begin
                        res_next.item.status = fspa_pkg::STATUS_DOUBLE;
                    end
                    else
                    begin
                        // push slot: clear mark, link to old head
                        wr_en     = 1'b1;
                        wr_addr   = reg_idx_wide[SLOT_W-1:0];
                        wr_data   = {1'b0, head_reg};
                        head_next = idx_link_wide[LINK_W-1:0];
                        res_next.item.status = fspa_pkg::STATUS_OK;
                    end
                end
            end

            default:
            begin
                state_next = fspa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/fixed_slot_pool_allocator_unit.sv =====
// Top level of the fixed slot pool allocator: sequencer, slot memory, result register.
//
//  Channel   Signals                  Direction  Transaction taken when
//  -------   ----------------------   ---------  ------------------------------
//  command   start, busy, cmd         in         start high and busy low at clk
//  result    done, result             out        done high at clk (no stall)
//
// Allocate and free: the accepting edge issues the read of the addressed
// slot word {in-use mark, link}, the next edge writes it back and updates
// the free-list head. The result is then registered, so a new command may
// enter on the cycle its result is shown. An unused code completes at once.
// A pool reset reports at once, then relinks the memory one entry per cycle
// with busy high; the same sweep runs after rst_n is released. The receiver
// cannot stall results.
module fixed_slot_pool_allocator_unit #(
    parameter int unsigned POOL_SLOTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  fspa_pkg::cmd_t     cmd,
    output logic               done,
    output fspa_pkg::result_t  result
);

    localparam int unsigned SLOT_W = $clog2(POOL_SLOTS);
    localparam int unsigned LINK_W = $clog2(POOL_SLOTS + 1);

    fspa_pkg::res_xfer_t res_next;
    logic                done_reg;
    fspa_pkg::result_t   result_reg;

    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic [LINK_W:0]     rd_data;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    logic [LINK_W:0]     wr_data;

    fspa_ctrl #(
        .POOL_SLOTS (POOL_SLOTS),
        .SLOT_W     (SLOT_W),
        .LINK_W     (LINK_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .busy     (busy),
        .res_next (res_next),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    // slot word: in-use mark on top, next link below
    fspa_slot_ram #(
        .DEPTH  (POOL_SLOTS),
        .WIDTH  (LINK_W + 1),
        .ADDR_W (SLOT_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Hold the strobe for exactly one cycle per completed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_next.strobe;
        end
    end

    // Capture the payload only when a transaction completes
    always_ff @(posedge clk)
    begin
        if (res_next.strobe)
        begin
            result_reg <= res_next.item;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
